[sv/configurable_byte_tokenizer_top_assert.svh]
`ifndef CONFIGURABLE_BYTE_TOKENIZER_TOP_ASSERT_SVH
`define CONFIGURABLE_BYTE_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication under the asynchronous reset.
`define CBT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication under the asynchronous reset.
`define CBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

[sv/cbt_pkg.sv]
package cbt_pkg;

	localparam int LINE_BITS = 24;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_SLASH = 8'd47;

	localparam logic [2:0] CLS_WS      = 3'd0;
	localparam logic [2:0] CLS_ALPHA   = 3'd1;
	localparam logic [2:0] CLS_DIGIT   = 3'd2;
	localparam logic [2:0] CLS_COMMENT = 3'd3;
	localparam logic [2:0] CLS_DELIM   = 3'd4;

	localparam logic [1:0] OP_DATA  = 2'd0;
	localparam logic [1:0] OP_EOS   = 2'd1;
	localparam logic [1:0] OP_CLASS = 2'd2;

	localparam logic [2:0] KIND_WORD  = 3'd0;
	localparam logic [2:0] KIND_NUM   = 3'd1;
	localparam logic [2:0] KIND_DELIM = 3'd2;
	localparam logic [2:0] KIND_EOL   = 3'd3;
	localparam logic [2:0] KIND_EOF   = 3'd4;

	localparam logic [2:0] CFG_EOL        = 3'd0;
	localparam logic [2:0] CFG_SKIP_LINE  = 3'd1;
	localparam logic [2:0] CFG_SKIP_BLOCK = 3'd2;
	localparam logic [2:0] CFG_CASE       = 3'd3;
	localparam logic [2:0] CFG_FIRST_LINE = 3'd4;

	localparam logic [1:0] CASE_UPPER = 2'd1;
	localparam logic [1:0] CASE_LOWER = 2'd2;

	localparam logic [1:0] CM_NONE       = 2'd0;
	localparam logic [1:0] CM_LINE       = 2'd1;
	localparam logic [1:0] CM_BLOCK      = 2'd2;
	localparam logic [1:0] CM_BLOCK_STAR = 2'd3;

	localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
		logic [2:0] cls;
		logic [2:0] slash_cls;
	} item_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic [7:0]           ch;
		logic                 tend;
		logic [LINE_BITS-1:0] line;
		logic                 last;
	} res_t;

	function automatic logic [2:0] default_class(input logic [7:0] c);
		return ((c >= 8'd33 && c < 8'd127) || c >= 8'd192) ? CLS_ALPHA : CLS_WS;
	endfunction

endpackage

[sv/cbt_in_if.sv]
interface cbt_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic [7:0] class_index;
	logic [2:0] class_value;

	modport source(output valid, opcode, data_byte, class_index, class_value, input ready);
	modport sink(input valid, opcode, data_byte, class_index, class_value, output ready);
endinterface

[sv/cbt_out_if.sv]
interface cbt_out_if;
	logic                           valid;
	logic                           ready;
	logic [2:0]                     token_kind;
	logic [7:0]                     token_char;
	logic                           token_end;
	logic [cbt_pkg::LINE_BITS-1:0]  line_number;
	logic                           run_last;

	modport source(output valid, token_kind, token_char, token_end, line_number, run_last,
		input ready);
	modport sink(input valid, token_kind, token_char, token_end, line_number, run_last,
		output ready);
endinterface

[sv/cbt_ram.sv]
module cbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/cbt_front.sv]
module cbt_front (
	input  logic               clk,
	input  logic               arst_n,
	cbt_in_if.sink             in_ch,
	output logic               push_valid,
	input  logic               push_ready,
	output cbt_pkg::item_t     push_data
);

	logic       accept;
	logic       is_write;
	logic [7:0] raddr;
	logic [2:0] ram_rdata;
	logic [255:0] vld_q;
	logic [2:0] slash_cls_q;

	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] ch_s1;
	logic [7:0] raddr_s1;
	logic       vbit_s1;
	logic [2:0] slash_cls_s1;

	assign in_ch.ready = !valid_s1 || push_ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_write    = accept && in_ch.opcode == cbt_pkg::OP_CLASS;
	// A carriage return is looked up as the line feed it turns into.
	assign raddr = (in_ch.data_byte == cbt_pkg::CH_CR) ? cbt_pkg::CH_LF : in_ch.data_byte;

	cbt_ram #(.WIDTH(3), .DEPTH(256)) u_class_ram (
		.clk   (clk),
		.we    (is_write),
		.waddr (in_ch.class_index),
		.wdata (in_ch.class_value),
		.re    (accept),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			slash_cls_q <= cbt_pkg::default_class(cbt_pkg::CH_SLASH);
			valid_s1    <= 1'b0;
		end else begin
			if (is_write) begin
				vld_q[in_ch.class_index] <= 1'b1;
				if (in_ch.class_index == cbt_pkg::CH_SLASH) begin
					slash_cls_q <= in_ch.class_value;
				end
			end
			if (accept && (in_ch.opcode == cbt_pkg::OP_DATA ||
					in_ch.opcode == cbt_pkg::OP_EOS)) begin
				valid_s1 <= 1'b1;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= in_ch.opcode;
			ch_s1        <= in_ch.data_byte;
			raddr_s1     <= raddr;
			vbit_s1      <= vld_q[raddr];
			slash_cls_s1 <= slash_cls_q;
		end
	end

	assign push_valid          = valid_s1;
	assign push_data.op        = op_s1;
	assign push_data.ch        = ch_s1;
	assign push_data.cls       = vbit_s1 ? ram_rdata : cbt_pkg::default_class(raddr_s1);
	assign push_data.slash_cls = slash_cls_s1;

endmodule

[sv/cbt_queue.sv]
module cbt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  cbt_pkg::item_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output cbt_pkg::item_t pop_data
);

	cbt_pkg::item_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = ent_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_data;
		end
	end

endmodule

[sv/cbt_back.sv]
module cbt_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [cbt_pkg::LINE_BITS-1:0] cfg_wdata,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  cbt_pkg::item_t                pop_data,
	cbt_out_if.source                     out_ch
);

	typedef struct packed {
		logic [7:0]                    hc;
		logic                          hv;
		logic                          hn;
		logic [cbt_pkg::LINE_BITS-1:0] line;
		cbt_pkg::res_t                 r0;
		cbt_pkg::res_t                 r1;
		logic [1:0]                    n;
	} tok_t;

	typedef struct packed {
		cbt_pkg::res_t [3:0] e;
		logic [2:0]          n;
	} rbuf_t;

	logic       eol_q;
	logic       skip_line_q;
	logic       skip_block_q;
	logic [1:0] case_q;

	logic [7:0]                    held_char_q;
	logic                          held_valid_q;
	logic                          held_num_q;
	logic                          prev_cr_q;
	logic                          slash_pend_q;
	logic [1:0]                    cmode_q;
	logic [cbt_pkg::LINE_BITS-1:0] line_q;

	cbt_pkg::res_t buf_q [4];
	logic [2:0]    rem_q;
	logic [1:0]    idx_q;

	tok_t       s;
	rbuf_t      b;
	logic [1:0] cm;
	logic       sp;
	logic       prev;
	logic       skip;
	logic       go;
	logic [7:0] c;
	logic       out_fire;

	function automatic cbt_pkg::res_t held_res(input logic [7:0] hc, input logic hn,
			input logic [1:0] cmode, input logic tend, input logic [cbt_pkg::LINE_BITS-1:0] line);
		cbt_pkg::res_t r;
		r.ch   = hc;
		r.kind = hn ? cbt_pkg::KIND_NUM : cbt_pkg::KIND_WORD;
		r.tend = tend;
		r.line = line;
		r.last = 1'b0;
		if (!hn && cmode == cbt_pkg::CASE_UPPER && hc >= "a" && hc <= "z") begin
			r.ch = hc - 8'd32;
		end else if (!hn && cmode == cbt_pkg::CASE_LOWER && hc >= "A" && hc <= "Z") begin
			r.ch = hc + 8'd32;
		end
		return r;
	endfunction

	function automatic cbt_pkg::res_t mk_res(input logic [2:0] kind, input logic [7:0] ch,
			input logic [cbt_pkg::LINE_BITS-1:0] line);
		cbt_pkg::res_t r;
		r.kind = kind;
		r.ch   = ch;
		r.tend = 1'b1;
		r.line = line;
		r.last = 1'b0;
		return r;
	endfunction

	// One character through the token builder; gives up to two results.
	function automatic tok_t tok(input tok_t si, input logic [7:0] ch, input logic [2:0] k,
			input logic eol, input logic [1:0] cmode);
		tok_t          t;
		logic          wordy;
		cbt_pkg::res_t r;
		t     = si;
		t.n   = 2'd0;
		t.r0  = '0;
		t.r1  = '0;
		r     = '0;
		wordy = (k == cbt_pkg::CLS_ALPHA) || (k == cbt_pkg::CLS_DIGIT);
		if (si.hv && wordy) begin
			t.r0 = held_res(si.hc, si.hn, cmode, 1'b0, si.line);
			t.n  = 2'd1;
			t.hc = ch;
		end else begin
			if (si.hv) begin
				t.r0 = held_res(si.hc, si.hn, cmode, 1'b1, si.line);
				t.n  = 2'd1;
				t.hv = 1'b0;
			end
			if (wordy) begin
				t.hc = ch;
				t.hv = 1'b1;
				t.hn = (k == cbt_pkg::CLS_DIGIT);
			end else if (k == cbt_pkg::CLS_DELIM) begin
				r = mk_res(cbt_pkg::KIND_DELIM, ch, t.line);
				if (t.n == 2'd0) t.r0 = r; else t.r1 = r;
				t.n = t.n + 2'd1;
			end else if (ch == cbt_pkg::CH_LF) begin
				if (t.line != cbt_pkg::LINE_MAX) begin
					t.line = t.line + 1'b1;
				end
				if (eol) begin
					r = mk_res(cbt_pkg::KIND_EOL, 8'd0, t.line);
					if (t.n == 2'd0) t.r0 = r; else t.r1 = r;
					t.n = t.n + 2'd1;
				end
			end
		end
		return t;
	endfunction

	function automatic rbuf_t push_res(input rbuf_t bi, input cbt_pkg::res_t r);
		rbuf_t bo;
		bo = bi;
		if (bi.n < 3'd4) begin
			bo.e[bi.n[1:0]] = r;
			bo.n = bi.n + 3'd1;
		end
		return bo;
	endfunction

	function automatic rbuf_t push_tok(input rbuf_t bi, input tok_t t);
		rbuf_t bo;
		bo = bi;
		if (t.n != 2'd0) bo = push_res(bo, t.r0);
		if (t.n == 2'd2) bo = push_res(bo, t.r1);
		return bo;
	endfunction

	assign out_fire  = out_ch.valid && out_ch.ready;
	assign pop_ready = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ch.ready);
	assign go        = pop_valid && pop_ready;

	always_comb begin
		s      = '0;
		s.hc   = held_char_q;
		s.hv   = held_valid_q;
		s.hn   = held_num_q;
		s.line = line_q;
		b      = '0;
		cm     = cmode_q;
		sp     = slash_pend_q;
		prev   = prev_cr_q;
		skip   = 1'b0;
		c      = pop_data.ch;
		if (pop_data.op == cbt_pkg::OP_DATA) begin
			if (pop_data.ch == cbt_pkg::CH_CR) begin
				prev = 1'b1;
				c    = cbt_pkg::CH_LF;
			end else if (pop_data.ch == cbt_pkg::CH_LF && prev_cr_q) begin
				prev = 1'b0;
				skip = 1'b1;
			end else begin
				prev = 1'b0;
			end
			if (!skip && cm == cbt_pkg::CM_NONE && sp) begin
				sp = 1'b0;
				if (c == cbt_pkg::CH_SLASH && skip_line_q) begin
					cm   = cbt_pkg::CM_LINE;
					skip = 1'b1;
				end else if (c == cbt_pkg::CH_STAR && skip_block_q) begin
					cm   = cbt_pkg::CM_BLOCK;
					skip = 1'b1;
				end else if (pop_data.slash_cls == cbt_pkg::CLS_COMMENT) begin
					cm = cbt_pkg::CM_LINE;
				end else begin
					s = tok(s, cbt_pkg::CH_SLASH, pop_data.slash_cls, eol_q, case_q);
					b = push_tok(b, s);
				end
			end
			if (!skip) begin
				case (cm)
					cbt_pkg::CM_LINE: begin
						if (c == cbt_pkg::CH_LF) begin
							cm = cbt_pkg::CM_NONE;
							s  = tok(s, c, pop_data.cls, eol_q, case_q);
							b  = push_tok(b, s);
						end
					end
					cbt_pkg::CM_BLOCK: begin
						if (c == cbt_pkg::CH_STAR) cm = cbt_pkg::CM_BLOCK_STAR;
					end
					cbt_pkg::CM_BLOCK_STAR: begin
						if (c == cbt_pkg::CH_SLASH) cm = cbt_pkg::CM_NONE;
						else if (c != cbt_pkg::CH_STAR) cm = cbt_pkg::CM_BLOCK;
					end
					default: begin
						if (c == cbt_pkg::CH_SLASH && (skip_line_q || skip_block_q)) begin
							sp = 1'b1;
						end else if (pop_data.cls == cbt_pkg::CLS_COMMENT) begin
							cm = cbt_pkg::CM_LINE;
						end else begin
							s = tok(s, c, pop_data.cls, eol_q, case_q);
							b = push_tok(b, s);
						end
					end
				endcase
			end
		end else begin
			// End of stream: settle a waiting slash, flush the held character, then EOF.
			if (sp && cm == cbt_pkg::CM_NONE && pop_data.slash_cls != cbt_pkg::CLS_COMMENT) begin
				s = tok(s, cbt_pkg::CH_SLASH, pop_data.slash_cls, eol_q, case_q);
				b = push_tok(b, s);
			end
			sp = 1'b0;
			if (s.hv) begin
				b    = push_res(b, held_res(s.hc, s.hn, case_q, 1'b1, s.line));
				s.hv = 1'b0;
			end
			b    = push_res(b, mk_res(cbt_pkg::KIND_EOF, 8'd0, s.line));
			cm   = cbt_pkg::CM_NONE;
			prev = 1'b0;
		end
		for (int i = 0; i < 4; i++) begin
			b.e[i].last = (3'(i) == b.n - 3'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eol_q        <= 1'b0;
			skip_line_q  <= 1'b0;
			skip_block_q <= 1'b0;
			case_q       <= 2'd0;
			held_char_q  <= 8'd0;
			held_valid_q <= 1'b0;
			held_num_q   <= 1'b0;
			prev_cr_q    <= 1'b0;
			slash_pend_q <= 1'b0;
			cmode_q      <= cbt_pkg::CM_NONE;
			line_q       <= {{(cbt_pkg::LINE_BITS-1){1'b0}}, 1'b1};
			rem_q        <= 3'd0;
			idx_q        <= 2'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cbt_pkg::CFG_EOL:        eol_q        <= cfg_wdata[0];
					cbt_pkg::CFG_SKIP_LINE:  skip_line_q  <= cfg_wdata[0];
					cbt_pkg::CFG_SKIP_BLOCK: skip_block_q <= cfg_wdata[0];
					cbt_pkg::CFG_CASE:       case_q       <= cfg_wdata[1:0];
					cbt_pkg::CFG_FIRST_LINE: line_q       <= cfg_wdata;
					default: ;
				endcase
			end
			if (go) begin
				held_char_q  <= s.hc;
				held_valid_q <= s.hv;
				held_num_q   <= s.hn;
				prev_cr_q    <= prev;
				slash_pend_q <= sp;
				cmode_q      <= cm;
				line_q       <= s.line;
				rem_q        <= b.n;
				idx_q        <= 2'd0;
			end else if (out_fire) begin
				rem_q <= rem_q - 3'd1;
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < 4; i++) begin
				buf_q[i] <= b.e[i];
			end
		end
	end

	assign out_ch.valid       = rem_q != 3'd0;
	assign out_ch.token_kind  = buf_q[idx_q].kind;
	assign out_ch.token_char  = buf_q[idx_q].ch;
	assign out_ch.token_end   = buf_q[idx_q].tend;
	assign out_ch.line_number = buf_q[idx_q].line;
	assign out_ch.run_last    = buf_q[idx_q].last;

endmodule

[sv/configurable_byte_tokenizer_top.sv]
// Byte tokenizer: one input item per clock is taken when the output keeps up. An item
// is registered in the front (the class table read is registered too, and
// classification follows from it) before it enters a two-entry queue; the back takes
// one item a cycle while the results of the last are out or going out, and hands out
// its zero to four results one per cycle while the output is ready. Class-write items
// update the 256-entry table RAM at once and give no result.
module configurable_byte_tokenizer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [cbt_pkg::LINE_BITS-1:0] cfg_wdata,
	cbt_in_if.sink                        in_ch,
	cbt_out_if.source                     out_ch
);

	logic           push_valid;
	logic           push_ready;
	cbt_pkg::item_t push_data;
	logic           pop_valid;
	logic           pop_ready;
	cbt_pkg::item_t pop_data;

	cbt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cbt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	cbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_ch    (out_ch)
	);

endmodule

[sv/cbt_checker.sv]
`include "configurable_byte_tokenizer_top_assert.svh"

module cbt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] token_kind,
	input logic [7:0] token_char,
	input logic       token_end,
	input logic       run_last
);

	`CBT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`CBT_ASSERT_SAME(a_eof_closes, clk, arst_n, out_valid && token_kind == cbt_pkg::KIND_EOF, token_end && run_last && token_char == 8'd0)
	`CBT_ASSERT_SAME(a_eol_empty, clk, arst_n, out_valid && token_kind == cbt_pkg::KIND_EOL, token_end && token_char == 8'd0)
	`CBT_ASSERT_SAME(a_delim_single, clk, arst_n, out_valid && token_kind == cbt_pkg::KIND_DELIM, token_end)

endmodule

bind configurable_byte_tokenizer_top cbt_checker u_cbt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.token_kind (out_ch.token_kind),
	.token_char (out_ch.token_char),
	.token_end  (out_ch.token_end),
	.run_last   (out_ch.run_last)
);

[tb/cbt_token_checker.sv]
`timescale 1ns / 1ps

module cbt_token_checker
	import cbt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [LINE_BITS-1:0] cfg_wdata,
	cbt_in_if                    in_ch,
	cbt_out_if                   out_ch,
	output int                   fail_count,
	output int                   tokens_pending
);

	logic [2:0]           cls_tab [256];
	logic [7:0]           hold_ch;
	logic                 hold_vld;
	logic                 hold_num;
	logic                 saw_cr;
	logic                 slash_wait;
	logic [1:0]           cmode;
	logic [LINE_BITS-1:0] line_cnt;

	logic                 eol_on;
	logic                 skip_line;
	logic                 skip_block;
	logic [1:0]           case_sel;

	res_t token_q [$];
	res_t step_toks [$];

	task automatic report(input string what, input int got, input int want);
		if (fail_count < 40)
			$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	function automatic void put_tok(input logic [2:0] k, input logic [7:0] c, input logic e);
		res_t r;
		if (step_toks.size() >= 4)
			return;
		r.kind = k;
		r.ch   = c;
		r.tend = e;
		r.line = line_cnt;
		r.last = 1'b0;
		step_toks.push_back(r);
	endfunction

	function automatic void put_held(input logic e);
		logic [7:0] c;
		c = hold_ch;
		if (hold_num) begin
			put_tok(KIND_NUM, c, e);
		end else begin
			if (case_sel == CASE_UPPER && c >= "a" && c <= "z")
				c = c - 8'd32;
			else if (case_sel == CASE_LOWER && c >= "A" && c <= "Z")
				c = c + 8'd32;
			put_tok(KIND_WORD, c, e);
		end
	endfunction

	function automatic void feed_token(input logic [7:0] c);
		logic [2:0] k;
		logic       wordy;
		k = cls_tab[c];
		wordy = (k == CLS_ALPHA || k == CLS_DIGIT);
		if (hold_vld) begin
			if (wordy) begin
				put_held(1'b0);
				hold_ch = c;
				return;
			end
			put_held(1'b1);
			hold_vld = 1'b0;
		end
		if (wordy) begin
			hold_ch  = c;
			hold_vld = 1'b1;
			hold_num = (k == CLS_DIGIT);
		end else if (k == CLS_DELIM) begin
			put_tok(KIND_DELIM, c, 1'b1);
		end else if (c == CH_LF) begin
			if (line_cnt != LINE_MAX)
				line_cnt++;
			if (eol_on)
				put_tok(KIND_EOL, 8'd0, 1'b1);
		end
	endfunction

	function automatic void feed_filter(input logic [7:0] c);
		if (cls_tab[c] == CLS_COMMENT)
			cmode = CM_LINE;
		else
			feed_token(c);
	endfunction

	function automatic void feed_comment(input logic [7:0] c);
		if (cmode == CM_NONE && slash_wait) begin
			slash_wait = 1'b0;
			if (c == CH_SLASH && skip_line) begin
				cmode = CM_LINE;
				return;
			end
			if (c == CH_STAR && skip_block) begin
				cmode = CM_BLOCK;
				return;
			end
			feed_filter(CH_SLASH);
		end
		case (cmode)
			CM_LINE: begin
				if (c == CH_LF) begin
					cmode = CM_NONE;
					feed_token(c);
				end
				return;
			end
			CM_BLOCK: begin
				if (c == CH_STAR)
					cmode = CM_BLOCK_STAR;
				return;
			end
			CM_BLOCK_STAR: begin
				if (c == CH_SLASH)
					cmode = CM_NONE;
				else if (c != CH_STAR)
					cmode = CM_BLOCK;
				return;
			end
			default: ;
		endcase
		if (c == CH_SLASH && (skip_line || skip_block)) begin
			slash_wait = 1'b1;
			return;
		end
		feed_filter(c);
	endfunction

	function automatic void predict_tokens(input logic [1:0] op, input logic [7:0] c,
			input logic [7:0] idx, input logic [2:0] val);
		step_toks.delete();
		if (op == OP_DATA) begin
			if (c == CH_CR) begin
				saw_cr = 1'b1;
				feed_comment(CH_LF);
			end else if (c == CH_LF && saw_cr) begin
				saw_cr = 1'b0;
			end else begin
				saw_cr = 1'b0;
				feed_comment(c);
			end
		end else if (op == OP_EOS) begin
			if (slash_wait && cmode == CM_NONE)
				feed_filter(CH_SLASH);
			slash_wait = 1'b0;
			if (hold_vld) begin
				put_held(1'b1);
				hold_vld = 1'b0;
			end
			put_tok(KIND_EOF, 8'd0, 1'b1);
			cmode  = CM_NONE;
			saw_cr = 1'b0;
		end else if (op == OP_CLASS) begin
			cls_tab[idx] = val;
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
		foreach (step_toks[i])
			token_q.push_back(step_toks[i]);
	endfunction

	assign tokens_pending = token_q.size();

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++)
				cls_tab[i] = ((i >= 33 && i < 127) || i >= 192) ? CLS_ALPHA : CLS_WS;
			hold_ch    = '0;
			hold_vld   = 1'b0;
			hold_num   = 1'b0;
			saw_cr     = 1'b0;
			slash_wait = 1'b0;
			cmode      = CM_NONE;
			eol_on     = 1'b0;
			skip_line  = 1'b0;
			skip_block = 1'b0;
			case_sel   = 2'd0;
			line_cnt   = LINE_BITS'(1);
			fail_count = 0;
			token_q.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (token_q.size() == 0) begin
					report("unexpected token item", out_ch.token_char, 0);
				end else begin
					want = token_q.pop_front();
					if (out_ch.token_kind !== want.kind)
						report("token_kind", out_ch.token_kind, want.kind);
					if (out_ch.token_char !== want.ch)
						report("token_char", out_ch.token_char, want.ch);
					if (out_ch.token_end !== want.tend)
						report("token_end", out_ch.token_end, want.tend);
					if (out_ch.line_number !== want.line)
						report("line_number", out_ch.line_number, want.line);
					if (out_ch.run_last !== want.last)
						report("run_last", out_ch.run_last, want.last);
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_tokens(in_ch.opcode, in_ch.data_byte, in_ch.class_index,
					in_ch.class_value);
			if (cfg_we) begin
				case (cfg_index)
					CFG_EOL:        eol_on = cfg_wdata[0];
					CFG_SKIP_LINE:  skip_line = cfg_wdata[0];
					CFG_SKIP_BLOCK: skip_block = cfg_wdata[0];
					CFG_CASE:       case_sel = cfg_wdata[1:0];
					CFG_FIRST_LINE: line_cnt = cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/configurable_byte_tokenizer_top_tb.sv]
`timescale 1ns / 1ps

module configurable_byte_tokenizer_top_tb;
	import cbt_pkg::*;

	localparam logic [1:0] OP_IGNORED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [2:0]           cfg_index;
	logic [LINE_BITS-1:0] cfg_wdata;
	int                   fail_count;
	int                   tokens_pending;
	bit                   long_hold;

	cbt_in_if  in_ch();
	cbt_out_if out_ch();

	configurable_byte_tokenizer_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
	);

	cbt_token_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .tokens_pending(tokens_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Token receiver: random stalls, plus one long hold-off on request.
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (150) @(posedge clk);
				long_hold = 1'b0;
			end
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(out_ch.valid && out_ch.ready))
				@(posedge clk);
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] c,
			input logic [7:0] idx, input logic [2:0] val);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.opcode      <= op;
		in_ch.data_byte   <= c;
		in_ch.class_index <= idx;
		in_ch.class_value <= val;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_item(OP_DATA, c, 8'($urandom), 3'($urandom));
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	task automatic set_class(input logic [7:0] idx, input logic [2:0] val);
		send_item(OP_CLASS, 8'($urandom), idx, val);
	endtask

	// Stops the sender and waits until every expected token has come out.
	task automatic drain_tokens;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [LINE_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic eol, input logic sl, input logic sb,
			input logic [1:0] cm, input logic [LINE_BITS-1:0] fl);
		write_reg(CFG_EOL, LINE_BITS'(eol));
		write_reg(CFG_SKIP_LINE, LINE_BITS'(sl));
		write_reg(CFG_SKIP_BLOCK, LINE_BITS'(sb));
		write_reg(CFG_CASE, LINE_BITS'(cm));
		write_reg(CFG_FIRST_LINE, fl);
	endtask

	function automatic logic [7:0] pick_char;
		string set;
		set = "aZq9 0/*\n\r;#,_xY5 ";
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	task automatic send_random;
		int r;
		r = $urandom_range(0, 99);
		if (r < 86)
			send_byte(pick_char());
		else if (r < 91)
			send_item(OP_EOS, 8'($urandom), 8'($urandom), 3'($urandom));
		else if (r < 97)
			set_class($urandom_range(0, 1) ? pick_char() : 8'($urandom),
				$urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) :
				3'($urandom_range(0, 4)));
		else
			send_item(OP_IGNORED, 8'($urandom), 8'($urandom), 3'($urandom));
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		long_hold         = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.opcode      = OP_DATA;
		in_ch.data_byte   = '0;
		in_ch.class_index = '0;
		in_ch.class_value = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: comments, line ends, class changes, end of stream.
		set_regs(1'b1, 1'b1, 1'b1, CASE_UPPER, 24'd1);
		set_class(";", CLS_DELIM);
		send_text("ab 9;\r\n\r//c\n/*x**/");
		send_text("/q");
		set_class("#", CLS_COMMENT);
		send_text("#z\n");
		set_class(CH_LF, 3'd5);
		send_byte(CH_LF);
		set_class(CH_LF, CLS_WS);
		send_item(OP_IGNORED, 8'hFF, 8'hFF, 3'd7);
		send_text("k/");
		send_item(OP_EOS, 8'd0, 8'd0, 3'd0);
		drain_tokens();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(1'b0, 1'b0, 1'b0, 2'd0, 24'd0);
				1: set_regs(1'b1, 1'b1, 1'b1, CASE_LOWER, 24'hFFFFFE);
				2: set_regs(1'b1, 1'b0, 1'b1, 2'd3, LINE_MAX);
				default: set_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
					LINE_BITS'($urandom));
			endcase
			// The receiver holds off while the sender keeps offering items.
			if (ph == 1)
				long_hold = 1'b1;
			for (int n = 0; n < 37; n++)
				send_random();
			drain_tokens();
		end

		if (fail_count == 0 && tokens_pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/cbt_pkg.sv
sv/cbt_in_if.sv
sv/cbt_out_if.sv
sv/cbt_ram.sv
sv/cbt_front.sv
sv/cbt_queue.sv
sv/cbt_back.sv
sv/configurable_byte_tokenizer_top.sv
sv/cbt_checker.sv
tb/cbt_token_checker.sv
tb/configurable_byte_tokenizer_top_tb.sv
